// ===== hdl/qoi_enc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// QOI encoder package
// Shared constants, chunk tags and the chunk record passed to the serializer.
// ----------------------------------------------------------------------------
package qoi_enc_pkg;

    localparam int SLOTS     = 64;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int PIX_W     = 32;
    localparam int MAX_BYTES = 6;
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);
    localparam int IDX_W     = $clog2(MAX_BYTES);

    localparam logic [5:0] RUN_MAX = 6'd62;

    localparam logic [7:0] TAG_INDEX = 8'h00;
    localparam logic [7:0] TAG_DIFF  = 8'h40;
    localparam logic [7:0] TAG_LUMA  = 8'h80;
    localparam logic [7:0] TAG_RUN   = 8'hC0;
    localparam logic [7:0] TAG_RGB   = 8'hFE;
    localparam logic [7:0] TAG_RGBA  = 8'hFF;

    localparam logic [31:0] PREV_RESET = 32'h0000_00FF;

    // register word index on the APB port
    localparam logic [0:0] REG_KEEP_ALPHA = 1'b0;

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
        logic                      eoi;
    } chunk_rec_t;

endpackage

// ===== hdl/qoi_enc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module qoi_enc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/qoi_enc_ser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// QOI chunk serializer
// Holds one chunk record and sends its bytes out one transfer at a time.
// ----------------------------------------------------------------------------
module qoi_enc_ser
    import qoi_enc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rec_valid,
    input  chunk_rec_t rec,
    output logic       rec_ready,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // code_byte
    output logic       m_axis_tuser,   // last_of_pixel
    output logic       m_axis_tlast
);

    chunk_rec_t       buf_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             valid_reg;
    logic             on_last;

    assign on_last   = (CNT_W'(idx_reg) == buf_reg.count - CNT_W'(1));
    assign rec_ready = !valid_reg || (on_last && m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (rec_valid && rec_ready)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (valid_reg && m_axis_tready)
        begin
            if (on_last)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_valid && rec_ready)
        begin
            buf_reg <= rec;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = buf_reg.bytes[idx_reg];
    assign m_axis_tuser  = on_last;
    assign m_axis_tlast  = on_last && buf_reg.eoi;

endmodule

// ===== hdl/qoi_pixel_encoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// QOI pixel encoder
// Streams RGBA pixels in and QOI chunk bytes out (no header, no end marker).
// ----------------------------------------------------------------------------
// Input stream: one pixel per transfer, tdata = {alpha, blue, green, red} with
// red in the low byte, tlast on the final pixel of the image.
// Output stream: one chunk byte per transfer, tuser on the last byte a pixel
// causes, tlast on the final byte of the image.
// APB register 0 (address 0x0), bit 0: keep_alpha, reset 1. Write it while the
// block is idle; clear it to code every pixel with alpha 255.
// A pixel is registered into the coding stage, and its chunk record into the
// serializer, before its first byte is on the output.
// Throughput: one pixel per cycle while the receiver is ready and each pixel
// gives at most one byte; a pixel that gives more waits on the one-byte
// output port. The color index is a 64 x 32 RAM read in the accept cycle and
// written back when the pixel leaves the coding stage, with forwarding of a
// same-slot write.
// Reset and the end of each image empty all index slots at once (valid flags),
// set the previous pixel to opaque black and the run to zero.
// When the receiver stalls, the output byte holds; a pending pixel with bytes
// to send holds too and s_axis_tready drops; nothing is lost.
// ----------------------------------------------------------------------------
module qoi_pixel_encoder_unit
    import qoi_enc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // pixel input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // red, green, blue, alpha
    input  logic        s_axis_tlast,   // last_pixel
    // chunk byte output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // code_byte
    output logic        m_axis_tuser,   // last_of_pixel
    output logic        m_axis_tlast,   // end_of_image
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ---------------- configuration ----------------
    logic keep_alpha_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_alpha_reg <= 1'b1;
        end
        else if (psel && penable && pwrite && pready && paddr[2:2] == REG_KEEP_ALPHA)
        begin
            keep_alpha_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2:2] == REG_KEEP_ALPHA) ? {31'd0, keep_alpha_reg} : 32'd0;

    // ---------------- accept stage ----------------
    logic [7:0]        in_r, in_g, in_b, in_a;
    logic [SLOT_W-1:0] in_slot;
    logic              accept;

    assign in_r    = s_axis_tdata[7:0];
    assign in_g    = s_axis_tdata[15:8];
    assign in_b    = s_axis_tdata[23:16];
    assign in_a    = keep_alpha_reg ? s_axis_tdata[31:24] : 8'hFF;
    assign in_slot = SLOT_W'(in_r[5:0] * 6'd3 + in_g[5:0] * 6'd5
                           + in_b[5:0] * 6'd7 + in_a[5:0] * 6'd11);
    assign accept  = s_axis_tvalid && s_axis_tready;

    // ---------------- index memory ----------------
    logic              wr_en;
    logic [PIX_W-1:0]  ram_q;
    logic [PIX_W-1:0]  s1_px_reg;
    logic [SLOT_W-1:0] s1_slot_reg;
    logic              s1_last_reg;
    logic              s1_valid_reg;
    logic              fwd_reg;
    logic [PIX_W-1:0]  fwd_data_reg;
    logic [SLOTS-1:0]  slot_valid_reg;
    logic [PIX_W-1:0]  prev_reg;
    logic [5:0]        run_reg;

    qoi_enc_ram #(
        .WIDTH (PIX_W),
        .DEPTH (SLOTS)
    ) u_index_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_slot_reg),
        .wr_data (s1_px_reg),
        .rd_en   (accept),
        .rd_addr (in_slot),
        .rd_data (ram_q)
    );

    // ---------------- coding stage ----------------
    logic [7:0]                r, g, b, a, pr, pg, pb;
    logic signed [7:0]         vr, vg, vb;
    logic signed [8:0]         dgr, dgb;
    logic [7:0]                vr_p2, vg_p2, vb_p2, vg_p32;
    logic [8:0]                dgr_p8, dgb_p8;
    logic [PIX_W-1:0]          held;
    logic                      same_px;
    logic                      hit;
    logic [5:0]                run_inc;
    logic                      emit_run;
    logic [7:0]                run_byte;
    logic [MAX_BYTES-2:0][7:0] chunk;
    logic [CNT_W-1:0]          chunk_n;
    logic [5:0]                run_next;
    logic                      write_slot;
    chunk_rec_t                rec;
    logic                      rec_ready;
    logic                      rec_load;
    logic                      s1_fire;

    assign r  = s1_px_reg[31:24];
    assign g  = s1_px_reg[23:16];
    assign b  = s1_px_reg[15:8];
    assign a  = s1_px_reg[7:0];
    assign pr = prev_reg[31:24];
    assign pg = prev_reg[23:16];
    assign pb = prev_reg[15:8];

    assign vr     = $signed(r - pr);
    assign vg     = $signed(g - pg);
    assign vb     = $signed(b - pb);
    assign dgr    = $signed({vr[7], vr}) - $signed({vg[7], vg});
    assign dgb    = $signed({vb[7], vb}) - $signed({vg[7], vg});
    assign vr_p2  = vr + 8'sd2;
    assign vg_p2  = vg + 8'sd2;
    assign vb_p2  = vb + 8'sd2;
    assign vg_p32 = vg + 8'sd32;
    assign dgr_p8 = dgr + 9'sd8;
    assign dgb_p8 = dgb + 9'sd8;

    // a slot written by the previous pixel in the read cycle comes from the bypass
    assign held    = slot_valid_reg[s1_slot_reg] ? (fwd_reg ? fwd_data_reg : ram_q) : '0;
    assign same_px = (s1_px_reg == prev_reg);
    assign hit     = (held == s1_px_reg);
    assign run_inc = run_reg + 6'd1;

    always_comb
    begin
        chunk      = '0;
        chunk_n    = '0;
        write_slot = 1'b0;
        emit_run   = 1'b0;
        run_next   = run_reg;
        run_byte   = TAG_RUN | {2'b00, run_reg - 6'd1};
        if (same_px)
        begin
            run_byte = TAG_RUN | {2'b00, run_reg};
            if (run_inc == RUN_MAX || s1_last_reg)
            begin
                emit_run = 1'b1;
                run_next = '0;
            end
            else
            begin
                run_next = run_inc;
            end
        end
        else
        begin
            emit_run = (run_reg != 6'd0);
            run_next = '0;
            if (hit)
            begin
                chunk[0] = TAG_INDEX | {2'b00, s1_slot_reg};
                chunk_n  = CNT_W'(1);
            end
            else
            begin
                write_slot = 1'b1;
                if (a == prev_reg[7:0])
                begin
                    if (vr >= -8'sd2 && vr <= 8'sd1 && vg >= -8'sd2 && vg <= 8'sd1
                        && vb >= -8'sd2 && vb <= 8'sd1)
                    begin
                        chunk[0] = TAG_DIFF | {2'b00, vr_p2[1:0], vg_p2[1:0], vb_p2[1:0]};
                        chunk_n  = CNT_W'(1);
                    end
                    else if (dgr >= -9'sd8 && dgr <= 9'sd7 && vg >= -8'sd32 && vg <= 8'sd31
                             && dgb >= -9'sd8 && dgb <= 9'sd7)
                    begin
                        chunk[0] = TAG_LUMA | {2'b00, vg_p32[5:0]};
                        chunk[1] = {dgr_p8[3:0], dgb_p8[3:0]};
                        chunk_n  = CNT_W'(2);
                    end
                    else
                    begin
                        chunk[0] = TAG_RGB;
                        chunk[1] = r;
                        chunk[2] = g;
                        chunk[3] = b;
                        chunk_n  = CNT_W'(4);
                    end
                end
                else
                begin
                    chunk[0] = TAG_RGBA;
                    chunk[1] = r;
                    chunk[2] = g;
                    chunk[3] = b;
                    chunk[4] = a;
                    chunk_n  = CNT_W'(5);
                end
            end
        end
    end

    // place the run flush ahead of the pixel's own chunk
    always_comb
    begin
        rec.eoi   = s1_last_reg;
        rec.count = chunk_n + CNT_W'(emit_run);
        for (int i = 0; i < MAX_BYTES; i++)
        begin
            if (emit_run)
            begin
                rec.bytes[i] = (i == 0) ? run_byte : chunk[(i == 0) ? 0 : i - 1];
            end
            else
            begin
                rec.bytes[i] = (i < MAX_BYTES - 1) ? chunk[(i < MAX_BYTES - 1) ? i : 0] : 8'h00;
            end
        end
    end

    assign s1_fire       = s1_valid_reg && (rec.count == '0 || rec_ready);
    assign rec_load      = s1_fire && (rec.count != '0);
    assign wr_en         = s1_fire && write_slot;
    assign s_axis_tready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            fwd_reg        <= 1'b0;
            slot_valid_reg <= '0;
            prev_reg       <= PREV_RESET;
            run_reg        <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_reg      <= wr_en && (s1_slot_reg == in_slot);
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                if (s1_last_reg)
                begin
                    slot_valid_reg <= '0;
                    prev_reg       <= PREV_RESET;
                    run_reg        <= '0;
                end
                else
                begin
                    if (wr_en)
                    begin
                        slot_valid_reg[s1_slot_reg] <= 1'b1;
                    end
                    prev_reg <= s1_px_reg;
                    run_reg  <= run_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg    <= {in_r, in_g, in_b, in_a};
            s1_slot_reg  <= in_slot;
            s1_last_reg  <= s_axis_tlast;
            fwd_data_reg <= s1_px_reg;
        end
    end

    qoi_enc_ser u_ser (
        .clk           (clk),
        .rst_n         (rst_n),
        .rec_valid     (rec_load),
        .rec           (rec),
        .rec_ready     (rec_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

`ifndef SYNTHESIS
    a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg < RUN_MAX)
        else $error("run count reached flush limit without flushing");

    a_image_clear: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_last_reg |=> slot_valid_reg == '0 && run_reg == 6'd0
                                   && prev_reg == PREV_RESET)
        else $error("state not cleared after last pixel");

    a_rec_count: assert property (@(posedge clk) disable iff (!rst_n)
        rec_load |-> rec.count <= CNT_W'(MAX_BYTES))
        else $error("chunk record exceeds six bytes");

    a_last_flush: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_last_reg |-> rec.count != '0)
        else $error("last pixel produced no byte");
`endif

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// QOI pixel encoder testbench
// Streams directed and random RGBA pixel images into the encoder. A tracker
// class predicts the chunk byte stream: runs, index hits, DIFF, LUMA, RGB and
// RGBA. It compares every output transfer with the oldest predicted byte. Both
// stream sides idle at random, and keep_alpha is rewritten over APB between
// phases.
// ----------------------------------------------------------------------------
module tb
    import qoi_enc_pkg::*;
();

    localparam int LONG_HOLD = 300;
    localparam int SETTLE    = 8;

    typedef struct packed {
        logic [7:0] code;
        logic       tail;
        logic       eoi;
    } chunk_byte_t;

    class chunk_tracker;
        logic [31:0]  color_cache[SLOTS];
        logic [31:0]  last_px;
        int unsigned  run_count;
        bit           alpha_kept;
        logic [7:0]   staged[$];
        chunk_byte_t  expected_bytes[$];
        int           errors;

        function new();
            alpha_kept = 1'b1;
            errors = 0;
            clear_image();
        endfunction

        function void clear_image();
            foreach (color_cache[i])
                color_cache[i] = '0;
            last_px = PREV_RESET;
            run_count = 0;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        // predict the chunk bytes of one accepted pixel
        function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                 logic [7:0] a_in, logic eoi);
            logic [7:0]  a;
            logic [31:0] px;
            int          slot;
            int          vr;
            int          vg;
            int          vb;
            int          dgr;
            int          dgb;
            int          n;
            a = alpha_kept ? a_in : 8'hFF;
            px = {r, g, b, a};
            staged.delete();
            if (px == last_px)
            begin
                run_count++;
                if (run_count >= RUN_MAX || eoi)
                begin
                    staged.push_back(TAG_RUN | 8'(run_count - 1));
                    run_count = 0;
                end
            end
            else
            begin
                slot = (int'(r) * 3 + int'(g) * 5 + int'(b) * 7 + int'(a) * 11) % SLOTS;
                if (run_count > 0)
                begin
                    staged.push_back(TAG_RUN | 8'(run_count - 1));
                    run_count = 0;
                end
                if (color_cache[slot] == px)
                    staged.push_back(TAG_INDEX | 8'(slot));
                else
                begin
                    color_cache[slot] = px;
                    if (a == last_px[7:0])
                    begin
                        vr = int'($signed(8'(r - last_px[31:24])));
                        vg = int'($signed(8'(g - last_px[23:16])));
                        vb = int'($signed(8'(b - last_px[15:8])));
                        dgr = vr - vg;
                        dgb = vb - vg;
                        if (vr > -3 && vr < 2 && vg > -3 && vg < 2 && vb > -3 && vb < 2)
                            staged.push_back(TAG_DIFF | 8'(((vr + 2) << 4) |
                                             ((vg + 2) << 2) | (vb + 2)));
                        else if (dgr > -9 && dgr < 8 && vg > -33 && vg < 32 &&
                                 dgb > -9 && dgb < 8)
                        begin
                            staged.push_back(TAG_LUMA | 8'(vg + 32));
                            staged.push_back(8'(((dgr + 8) << 4) | (dgb + 8)));
                        end
                        else
                        begin
                            staged.push_back(TAG_RGB);
                            staged.push_back(r);
                            staged.push_back(g);
                            staged.push_back(b);
                        end
                    end
                    else
                    begin
                        staged.push_back(TAG_RGBA);
                        staged.push_back(r);
                        staged.push_back(g);
                        staged.push_back(b);
                        staged.push_back(a);
                    end
                end
            end
            last_px = px;
            n = staged.size();
            for (int i = 0; i < n; i++)
                expected_bytes.push_back('{staged[i], i == n - 1, (i == n - 1) && eoi});
            if (eoi)
                clear_image();
        endfunction

        function void check_byte(logic [7:0] code, logic tail, logic eoi);
            chunk_byte_t want;
            if (expected_bytes.size() == 0)
            begin
                $error("code_byte: expected none, actual %h", code);
                errors++;
                return;
            end
            want = expected_bytes.pop_front();
            if (code !== want.code)
            begin
                $error("code_byte: expected %h, actual %h", want.code, code);
                errors++;
            end
            if (tail !== want.tail)
            begin
                $error("last_of_pixel: expected %0d, actual %0d", want.tail, tail);
                errors++;
            end
            if (eoi !== want.eoi)
            begin
                $error("end_of_image: expected %0d, actual %0d", want.eoi, eoi);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // red, green, blue, alpha
    logic        s_axis_tlast;   // last_pixel
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // code_byte
    logic        m_axis_tuser;   // last_of_pixel
    logic        m_axis_tlast;   // end_of_image
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    chunk_tracker sb;
    bit           quiet_tail = 1'b0;
    bit           long_hold_req = 1'b0;
    logic [7:0]   gen_r, gen_g, gen_b, gen_a;
    logic [31:0]  recent_colors[$];

    qoi_pixel_encoder_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #1 clk = ~clk;

    // pixel transfers feed the prediction, byte transfers are checked
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_pixel(s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16],
                              s_axis_tdata[31:24], s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_byte(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    // byte receiver: random stalls, one long hold on request
    initial
    begin : byte_sink
        int stall;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 7) == 0)
            begin
                stall = $urandom_range(1, 14);
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                              logic [7:0] a, logic lst);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {a, b, g, r};
        s_axis_tlast  <= lst;
        do @(posedge clk); while (s_axis_tready !== 1'b1);
        if (!quiet_tail && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    // hold input until every predicted byte has come out, then let the pipe settle
    task automatic drain_and_settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_keep_alpha(bit value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_KEEP_ALPHA, 2'b00};
        pwdata  <= {31'b0, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        sb.alpha_kept = value;
        // read back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (prdata[0] !== value)
        begin
            $error("keep_alpha: expected %0d, actual %0d", value, prdata[0]);
            sb.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_random_pixels(int count, bit open_with_run);
        int         sent;
        int         pick;
        int         reps;
        int         dv;
        logic [7:0] r, g, b, a;
        logic       lst;
        sent = 0;
        while (sent < count)
        begin
            pick = (open_with_run && sent == 0) ? 0 : $urandom_range(0, 99);
            reps = 1;
            {r, g, b, a} = {gen_r, gen_g, gen_b, gen_a};
            if (pick < 2)
                reps = $urandom_range(58, 66);
            else if (pick < 22)
                ;   // repeat the previous color
            else if (pick < 44)
            begin
                r = gen_r + 8'($urandom_range(0, 3)) - 8'd2;
                g = gen_g + 8'($urandom_range(0, 3)) - 8'd2;
                b = gen_b + 8'($urandom_range(0, 3)) - 8'd2;
            end
            else if (pick < 62)
            begin
                dv = $urandom_range(0, 63) - 32;
                g = 8'(int'(gen_g) + dv);
                r = 8'(int'(gen_r) + dv + $urandom_range(0, 15) - 8);
                b = 8'(int'(gen_b) + dv + $urandom_range(0, 15) - 8);
            end
            else if (pick < 72)
                {r, g, b} = 24'($urandom());
            else if (pick < 80)
                {r, g, b, a} = $urandom();
            else if (pick < 92 && recent_colors.size() > 0)
                {r, g, b, a} = recent_colors[$urandom_range(0, recent_colors.size() - 1)];
            else
            begin
                // noise: odd alpha changes and an occasional all-zero pixel
                {r, g, b, a} = $urandom();
                if ($urandom_range(0, 3) == 0)
                    {r, g, b, a} = '0;
            end
            {gen_r, gen_g, gen_b, gen_a} = {r, g, b, a};
            recent_colors.push_back({r, g, b, a});
            if (recent_colors.size() > 16)
                void'(recent_colors.pop_front());
            for (int k = 0; k < reps; k++)
            begin
                lst = (k == reps - 1) &&
                      ($urandom_range(0, reps > 1 ? 3 : 29) == 0);
                send_pixel(r, g, b, a, lst);
                sent++;
            end
            if (lst)
                {gen_r, gen_g, gen_b, gen_a} = PREV_RESET;
        end
    endtask

    initial
    begin : main
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        {gen_r, gen_g, gen_b, gen_a} = PREV_RESET;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        write_keep_alpha(1'b1);

        // opaque black extends a run from reset; transparent black hits the empty slot
        send_pixel(8'd0, 8'd0, 8'd0, 8'd255, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(8'd1, 8'd0, 8'd255, 8'd0, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd0, 1'b0);
        send_pixel(8'd200, 8'd100, 8'd50, 8'd0, 1'b0);
        send_pixel(8'd210, 8'd110, 8'd60, 8'd0, 1'b0);
        send_pixel(8'd170, 8'd78, 8'd35, 8'd0, 1'b0);
        send_pixel(8'd170, 8'd78, 8'd35, 8'd128, 1'b0);
        send_pixel(8'd200, 8'd100, 8'd50, 8'd0, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
        // single-pixel images: a run of one, then an index hit
        send_pixel(8'd0, 8'd0, 8'd0, 8'd255, 1'b1);
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
        // wrapped deltas
        send_pixel(8'd255, 8'd1, 8'd0, 8'd255, 1'b0);
        send_pixel(8'd1, 8'd255, 8'd0, 8'd255, 1'b0);
        send_pixel(8'd1, 8'd255, 8'd0, 8'd255, 1'b0);

        // change keep_alpha in the middle of an open image
        drain_and_settle();
        write_keep_alpha(1'b0);
        send_pixel(8'd1, 8'd255, 8'd0, 8'd37, 1'b0);
        send_pixel(8'd9, 8'd9, 8'd9, 8'd0, 1'b1);
        {gen_r, gen_g, gen_b, gen_a} = PREV_RESET;
        run_random_pixels(80, 1'b0);

        // receiver holds off while pixels keep coming
        drain_and_settle();
        write_keep_alpha(1'b1);
        long_hold_req = 1'b1;
        run_random_pixels(95, 1'b1);

        drain_and_settle();
        write_keep_alpha(1'b0);
        run_random_pixels(30, 1'b0);

        drain_and_settle();
        write_keep_alpha(1'b1);
        quiet_tail = 1'b1;
        run_random_pixels(40, 1'b0);

        drain_and_settle();
        if (sb.errors == 0)
            $display("** qoi_pixel_encoder_unit: PASSED **");
        else
            $display("** qoi_pixel_encoder_unit: FAILED **");
        $finish;
    end

    initial
    begin : watchdog
        #1_000_000;
        $display("** qoi_pixel_encoder_unit: FAILED **");
        $finish;
    end

endmodule
